// ===== hdl/nonparametric_cusum_detector_macros.svh =====
// assertion macros for the nonparametric cusum detector
// no dependencies; included by the modules that carry checks
`ifndef NONPARAMETRIC_CUSUM_DETECTOR_MACROS_SVH
`define NONPARAMETRIC_CUSUM_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NPC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("npcusum: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define NPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("npcusum: next-cycle check failed");

`endif

// ===== hdl/npcusum_pkg.sv =====
// shared types, constants and helpers for the nonparametric cusum detector
// no dependencies
`timescale 1ns / 1ps

package npcusum_pkg;

    localparam int MAX_GROUP_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int GROUP_W   = 5;
    localparam int REF_W     = 16;
    localparam int LIMIT_W   = 20;
    localparam int STEP_W    = 20;
    localparam int SUM_W     = 24;
    localparam int STAT_OUT_W = 13;
    localparam int TERM_W    = 6;

    localparam int OUT_FIELDS_W = STAT_OUT_W + 2 * SUM_W + STEP_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CHART_MODE     = 3'd0,
        REG_GROUP_SIZE     = 3'd1,
        REG_REF_VALUE      = 3'd2,
        REG_DECISION_LIMIT = 3'd3,
        REG_MAX_STEPS      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               chart_mode;
        logic [GROUP_W-1:0] group_size;
        logic [REF_W-1:0]   ref_value;
        logic [LIMIT_W-1:0] decision_limit;
        logic [STEP_W-1:0]  max_steps;
    } cfg_t;

    localparam logic               CHART_MODE_RST     = 1'b0;
    localparam logic [GROUP_W-1:0] GROUP_SIZE_RST     = 5'd5;
    localparam logic [REF_W-1:0]   REF_VALUE_RST      = 16'd16;
    localparam logic [LIMIT_W-1:0] DECISION_LIMIT_RST = 20'd160;
    localparam logic [STEP_W-1:0]  MAX_STEPS_RST      = 20'd1000;

    localparam logic CHART_SIGN = 1'b0;
    localparam logic CHART_RANK = 1'b1;

    // per-sample class handed from the front to the back
    typedef struct packed {
        logic neg;
        logic zero;
        logic close;
    } smp_flags_t;

    localparam int FLAGS_W = 3;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_SUMS,
        B_OUT
    } back_state_t;

    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== hdl/npcusum_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies beyond the package helper for address width
`timescale 1ns / 1ps

module npcusum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [npcusum_pkg::idx_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [npcusum_pkg::idx_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/npcusum_queue.sv =====
// small fifo that decouples the sample front end from the statistic back end
// depends on npcusum_pkg
`timescale 1ns / 1ps

module npcusum_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = npcusum_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = npcusum_pkg::idx_w(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/npcusum_front.sv =====
// front end: takes samples, forms magnitude and sign class, tracks subgroup fill
// depends on npcusum_pkg
`timescale 1ns / 1ps

module npcusum_front #(
    parameter int MAX_GROUP   = npcusum_pkg::MAX_GROUP_DEF,
    parameter int SAMPLE_BITS = npcusum_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [npcusum_pkg::GROUP_W-1:0]           group_size,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [SAMPLE_BITS-1:0]                    s_sample,
    input  logic                                      q_full,
    output logic                                      q_push,
    output logic [SAMPLE_BITS-1:0]                    q_mag,
    output logic [npcusum_pkg::idx_w(MAX_GROUP)-1:0]  q_idx,
    output npcusum_pkg::smp_flags_t                   q_flags
);

    localparam int IDX_W = npcusum_pkg::idx_w(MAX_GROUP);
    localparam int CNTW  = $clog2(MAX_GROUP + 1);
    localparam int NW    = ((CNTW > npcusum_pkg::GROUP_W) ? CNTW : npcusum_pkg::GROUP_W) + 1;

    logic [IDX_W-1:0] fill_reg, fill_next;
    logic [NW-1:0]    size_ext;
    logic [NW-1:0]    size_eff;
    logic [NW-1:0]    fill_plus;
    logic             close;
    logic             neg;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // zero size acts as one, oversize clamps to the store depth
    always_comb begin
        size_ext = {{(NW - npcusum_pkg::GROUP_W){1'b0}}, group_size};
        if (size_ext == '0) begin
            size_eff = NW'(1);
        end else if (size_ext > NW'(MAX_GROUP)) begin
            size_eff = NW'(MAX_GROUP);
        end else begin
            size_eff = size_ext;
        end
    end

    assign fill_plus = {{(NW - IDX_W){1'b0}}, fill_reg} + 1'b1;
    assign close     = (fill_plus >= size_eff);
    assign fill_next = close ? '0 : fill_plus[IDX_W-1:0];

    assign neg   = s_sample[SAMPLE_BITS-1];
    assign q_mag = neg ? (~s_sample + 1'b1) : s_sample;
    assign q_idx = fill_reg;

    always_comb begin
        q_flags.neg   = neg;
        q_flags.zero  = (s_sample == '0);
        q_flags.close = close;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (q_push) begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== hdl/npcusum_back.sv =====
// back end: accumulates the subgroup statistic, updates both cusum sums, holds the result
// depends on npcusum_pkg, npcusum_ram and the assertion macro header
`timescale 1ns / 1ps
`include "nonparametric_cusum_detector_macros.svh"

module npcusum_back #(
    parameter int MAX_GROUP   = npcusum_pkg::MAX_GROUP_DEF,
    parameter int SAMPLE_BITS = npcusum_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  npcusum_pkg::cfg_t                         cfg,
    input  logic                                      q_empty,
    output logic                                      q_pop,
    input  logic [SAMPLE_BITS-1:0]                    q_mag,
    input  logic [npcusum_pkg::idx_w(MAX_GROUP)-1:0]  q_idx,
    input  npcusum_pkg::smp_flags_t                   q_flags,
    input  logic                                      m_ready,
    output logic                                      m_valid,
    output logic [npcusum_pkg::STAT_OUT_W-1:0]        out_stat,
    output logic [npcusum_pkg::SUM_W-1:0]             out_upper,
    output logic [npcusum_pkg::SUM_W-1:0]             out_lower,
    output logic                                      out_upper_alarm,
    output logic                                      out_lower_alarm,
    output logic                                      out_run_ended,
    output logic [npcusum_pkg::STEP_W-1:0]            out_run_length
);

    localparam int IDX_W    = npcusum_pkg::idx_w(MAX_GROUP);
    localparam int ENTRY_W  = SAMPLE_BITS + 2;
    localparam int STAT_RAW = $clog2(8 * MAX_GROUP * (MAX_GROUP + 1) + 1) + 1;
    localparam int STAT_W   = (STAT_RAW > npcusum_pkg::STAT_OUT_W) ? STAT_RAW
                                                                   : npcusum_pkg::STAT_OUT_W;
    localparam int SUMX_W   = ((STAT_W > npcusum_pkg::SUM_W) ? STAT_W : npcusum_pkg::SUM_W) + 3;
    localparam int TW       = npcusum_pkg::TERM_W;
    localparam int SW       = npcusum_pkg::SUM_W;

    localparam logic signed [TW-1:0] TERM_POS = 6'sd16;
    localparam logic signed [TW-1:0] TERM_NEG = -6'sd16;

    // rank contribution of one pair: the larger magnitude gains a full rank step,
    // a tie splits it between both samples
    function automatic logic signed [TW-1:0] pair_term(
        input logic [SAMPLE_BITS-1:0] mag_a,
        input logic                   neg_a,
        input logic                   zero_a,
        input logic [SAMPLE_BITS-1:0] mag_b,
        input logic                   neg_b,
        input logic                   zero_b
    );
        logic signed [1:0]    sa;
        logic signed [1:0]    sb;
        logic signed [2:0]    ssum;
        logic signed [TW-1:0] term;
        sa   = zero_a ? 2'sb00 : (neg_a ? 2'sb11 : 2'sb01);
        sb   = zero_b ? 2'sb00 : (neg_b ? 2'sb11 : 2'sb01);
        ssum = {sa[1], sa} + {sb[1], sb};
        if (mag_b < mag_a) begin
            term = $signed({sa, 4'b0000});
        end else if (mag_a < mag_b) begin
            term = $signed({sb, 4'b0000});
        end else begin
            term = $signed({ssum, 3'b000});
        end
        return term;
    endfunction

    npcusum_pkg::back_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0]  cur_mag_reg, cur_mag_next;
    logic                    cur_neg_reg, cur_neg_next;
    logic                    cur_zero_reg, cur_zero_next;
    logic                    cur_close_reg, cur_close_next;
    logic [IDX_W-1:0]        cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0]        issue_reg, issue_next;
    logic                    rvalid_reg, rvalid_next;
    logic signed [STAT_W-1:0] acc_reg, acc_next;
    logic signed [STAT_W-1:0] sgn_acc_reg, sgn_acc_next;
    logic [SW-1:0]           up_reg, up_next;
    logic [SW-1:0]           down_reg, down_next;
    logic [npcusum_pkg::STEP_W-1:0] step_reg, step_next;

    logic                    m_valid_reg, m_valid_next;
    logic [npcusum_pkg::STAT_OUT_W-1:0] o_stat_reg, o_stat_next;
    logic [SW-1:0]           o_upper_reg, o_upper_next;
    logic [SW-1:0]           o_lower_reg, o_lower_next;
    logic                    o_ua_reg, o_ua_next;
    logic                    o_la_reg, o_la_next;
    logic                    o_end_reg, o_end_next;
    logic [npcusum_pkg::STEP_W-1:0] o_len_reg, o_len_next;

    logic                    ram_we;
    logic                    ram_re;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic signed [TW-1:0]    own_term;
    logic signed [TW-1:0]    own_sign;
    logic signed [TW-1:0]    scan_term;
    logic signed [STAT_W-1:0] stat_sel;
    logic signed [SUMX_W-1:0] up_raw;
    logic signed [SUMX_W-1:0] down_raw;
    logic signed [SUMX_W-1:0] up_ext;
    logic signed [SUMX_W-1:0] down_ext;
    logic signed [SUMX_W-1:0] stat_ext;
    logic signed [SUMX_W-1:0] ref_ext;
    logic signed [SUMX_W-1:0] sat_ext;
    logic                    ua;
    logic                    la;
    logic                    ended;
    logic                    slot_free;

    npcusum_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_GROUP)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {q_flags.zero, q_flags.neg, q_mag};

    // both statistics are kept so the mode in force at the subgroup end decides
    always_comb begin
        own_sign = q_flags.neg ? TERM_NEG : TERM_POS;
        own_term = q_flags.zero ? '0 : own_sign;
    end

    assign scan_term = pair_term(cur_mag_reg, cur_neg_reg, cur_zero_reg,
                                 ram_rdata[SAMPLE_BITS-1:0], ram_rdata[SAMPLE_BITS],
                                 ram_rdata[SAMPLE_BITS+1]);

    assign stat_sel = (cfg.chart_mode == npcusum_pkg::CHART_RANK) ? acc_reg : sgn_acc_reg;

    assign up_ext   = $signed({{(SUMX_W - SW){1'b0}}, up_reg});
    assign down_ext = $signed({{(SUMX_W - SW){1'b0}}, down_reg});
    assign stat_ext = {{(SUMX_W - STAT_W){stat_sel[STAT_W-1]}}, stat_sel};
    assign ref_ext  = $signed({{(SUMX_W - npcusum_pkg::REF_W){1'b0}}, cfg.ref_value});
    assign sat_ext  = $signed({{(SUMX_W - SW){1'b0}}, {SW{1'b1}}});
    assign up_raw   = up_ext + stat_ext - ref_ext;
    assign down_raw = down_ext - stat_ext - ref_ext;

    assign ua    = (up_reg >= {{(SW - npcusum_pkg::LIMIT_W){1'b0}}, cfg.decision_limit});
    assign la    = (down_reg >= {{(SW - npcusum_pkg::LIMIT_W){1'b0}}, cfg.decision_limit});
    assign ended = ua || la || (step_reg >= cfg.max_steps);
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        cur_mag_next   = cur_mag_reg;
        cur_neg_next   = cur_neg_reg;
        cur_zero_next  = cur_zero_reg;
        cur_close_next = cur_close_reg;
        cur_idx_next   = cur_idx_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        acc_next       = acc_reg;
        sgn_acc_next   = sgn_acc_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        step_next      = step_reg;
        o_stat_next    = o_stat_reg;
        o_upper_next   = o_upper_reg;
        o_lower_next   = o_lower_reg;
        o_ua_next      = o_ua_reg;
        o_la_next      = o_la_reg;
        o_end_next     = o_end_reg;
        o_len_next     = o_len_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            npcusum_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop          = 1'b1;
                    ram_we         = 1'b1;
                    cur_mag_next   = q_mag;
                    cur_neg_next   = q_flags.neg;
                    cur_zero_next  = q_flags.zero;
                    cur_close_next = q_flags.close;
                    cur_idx_next   = q_idx;
                    issue_next     = '0;
                    // first sample of a subgroup restarts the statistic
                    acc_next = ((q_idx == '0) ? '0 : acc_reg)
                               + {{(STAT_W - TW){own_term[TW-1]}}, own_term};
                    sgn_acc_next = ((q_idx == '0) ? '0 : sgn_acc_reg)
                                   + {{(STAT_W - TW){own_sign[TW-1]}}, own_sign};
                    if (q_idx != '0) begin
                        state_next = npcusum_pkg::B_SCAN;
                    end else if (q_flags.close) begin
                        state_next = npcusum_pkg::B_SUMS;
                    end
                end
            end
            npcusum_pkg::B_SCAN: begin
                // compare the new sample against every earlier one of the subgroup
                ram_re      = (issue_reg < cur_idx_reg);
                rvalid_next = ram_re;
                if (ram_re) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (rvalid_reg) begin
                    acc_next = acc_reg + {{(STAT_W - TW){scan_term[TW-1]}}, scan_term};
                end
                if (issue_reg == cur_idx_reg) begin
                    state_next = cur_close_reg ? npcusum_pkg::B_SUMS : npcusum_pkg::B_IDLE;
                end
            end
            npcusum_pkg::B_SUMS: begin
                if (up_raw < 0) begin
                    up_next = '0;
                end else if (up_raw > sat_ext) begin
                    up_next = {SW{1'b1}};
                end else begin
                    up_next = up_raw[SW-1:0];
                end
                if (down_raw < 0) begin
                    down_next = '0;
                end else if (down_raw > sat_ext) begin
                    down_next = {SW{1'b1}};
                end else begin
                    down_next = down_raw[SW-1:0];
                end
                step_next  = step_reg + 1'b1;
                state_next = npcusum_pkg::B_OUT;
            end
            npcusum_pkg::B_OUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    o_stat_next  = stat_sel[npcusum_pkg::STAT_OUT_W-1:0];
                    o_upper_next = up_reg;
                    o_lower_next = down_reg;
                    o_ua_next    = ua;
                    o_la_next    = la;
                    o_end_next   = ended;
                    o_len_next   = step_reg;
                    if (ended) begin
                        up_next   = '0;
                        down_next = '0;
                        step_next = '0;
                    end
                    state_next = npcusum_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = npcusum_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= npcusum_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
            up_reg      <= '0;
            down_reg    <= '0;
            step_reg    <= '0;
            rvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            up_reg      <= up_next;
            down_reg    <= down_next;
            step_reg    <= step_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_mag_reg   <= cur_mag_next;
        cur_neg_reg   <= cur_neg_next;
        cur_zero_reg  <= cur_zero_next;
        cur_close_reg <= cur_close_next;
        cur_idx_reg   <= cur_idx_next;
        issue_reg     <= issue_next;
        acc_reg       <= acc_next;
        sgn_acc_reg   <= sgn_acc_next;
        o_stat_reg    <= o_stat_next;
        o_upper_reg   <= o_upper_next;
        o_lower_reg   <= o_lower_next;
        o_ua_reg      <= o_ua_next;
        o_la_reg      <= o_la_next;
        o_end_reg     <= o_end_next;
        o_len_reg     <= o_len_next;
    end

    assign m_valid         = m_valid_reg;
    assign out_stat        = o_stat_reg;
    assign out_upper       = o_upper_reg;
    assign out_lower       = o_lower_reg;
    assign out_upper_alarm = o_ua_reg;
    assign out_lower_alarm = o_la_reg;
    assign out_run_ended   = o_end_reg;
    assign out_run_length  = o_len_reg;

    `NPC_ASSERT_IMPL(a_scan_in_range, aclk, aresetn, state_reg == npcusum_pkg::B_SCAN, issue_reg <= cur_idx_reg)
    `NPC_ASSERT_IMPL(a_scan_has_peers, aclk, aresetn, state_reg == npcusum_pkg::B_SCAN, cur_idx_reg != '0)
    `NPC_ASSERT_IMPL(a_step_nonzero, aclk, aresetn, state_reg == npcusum_pkg::B_OUT, step_reg != '0)
    `NPC_ASSERT_NEXT(a_run_clears, aclk, aresetn, state_reg == npcusum_pkg::B_OUT && slot_free && ended, up_reg == '0 && down_reg == '0 && step_reg == '0)

endmodule

// ===== hdl/nonparametric_cusum_detector.sv =====
// top level of the two-sided sign / signed-rank cusum detector
// depends on npcusum_pkg, npcusum_front, npcusum_queue, npcusum_back
//
// channel  dir  handshake        payload
// s_axis   in   tvalid / tready  tdata: sample
// m_axis   out  tvalid / tready  tdata: statistic, sums, run length; tuser: alarms; tlast: run end
// cfg      in   cfg_we           cfg_addr, cfg_wdata
//
// in either mode one comparator walks the stored subgroup through the store ram port, so
// each new word of a subgroup is compared with every earlier one before the next is taken;
// both statistics are formed, and a closing word is followed by the sums update and then
// the result hand-off.
// reset clears the sums, the step count, the fill count and the queue; the store needs none.
// the two-entry queue lets the input side keep taking words while the back end scans,
// and a held result only stalls the back end at the next subgroup end.
`timescale 1ns / 1ps

module nonparametric_cusum_detector #(
    parameter int MAX_GROUP   = npcusum_pkg::MAX_GROUP_DEF,
    parameter int SAMPLE_BITS = npcusum_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // group_statistic, upper_sum, lower_sum, run_length
    output logic [npcusum_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // upper_alarm, lower_alarm
    output logic [npcusum_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_we,
    input  logic [npcusum_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [npcusum_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W = npcusum_pkg::idx_w(MAX_GROUP);
    localparam int Q_W   = npcusum_pkg::FLAGS_W + IDX_W + SAMPLE_BITS;

    npcusum_pkg::cfg_t       cfg_reg;

    logic                    q_push;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_empty;
    logic [SAMPLE_BITS-1:0]  f_mag;
    logic [IDX_W-1:0]        f_idx;
    npcusum_pkg::smp_flags_t f_flags;
    logic [Q_W-1:0]          q_out;
    logic [SAMPLE_BITS-1:0]  b_mag;
    logic [IDX_W-1:0]        b_idx;
    npcusum_pkg::smp_flags_t b_flags;

    logic [npcusum_pkg::STAT_OUT_W-1:0] o_stat;
    logic [npcusum_pkg::SUM_W-1:0]      o_upper;
    logic [npcusum_pkg::SUM_W-1:0]      o_lower;
    logic                               o_ua;
    logic                               o_la;
    logic                               o_end;
    logic [npcusum_pkg::STEP_W-1:0]     o_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chart_mode     <= npcusum_pkg::CHART_MODE_RST;
            cfg_reg.group_size     <= npcusum_pkg::GROUP_SIZE_RST;
            cfg_reg.ref_value      <= npcusum_pkg::REF_VALUE_RST;
            cfg_reg.decision_limit <= npcusum_pkg::DECISION_LIMIT_RST;
            cfg_reg.max_steps      <= npcusum_pkg::MAX_STEPS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                npcusum_pkg::REG_CHART_MODE: begin
                    cfg_reg.chart_mode <= cfg_wdata[0];
                end
                npcusum_pkg::REG_GROUP_SIZE: begin
                    cfg_reg.group_size <= cfg_wdata[npcusum_pkg::GROUP_W-1:0];
                end
                npcusum_pkg::REG_REF_VALUE: begin
                    cfg_reg.ref_value <= cfg_wdata[npcusum_pkg::REF_W-1:0];
                end
                npcusum_pkg::REG_DECISION_LIMIT: begin
                    cfg_reg.decision_limit <= cfg_wdata[npcusum_pkg::LIMIT_W-1:0];
                end
                npcusum_pkg::REG_MAX_STEPS: begin
                    cfg_reg.max_steps <= cfg_wdata[npcusum_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    npcusum_front #(
        .MAX_GROUP   (MAX_GROUP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .group_size (cfg_reg.group_size),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_mag      (f_mag),
        .q_idx      (f_idx),
        .q_flags    (f_flags)
    );

    npcusum_queue #(
        .WIDTH (Q_W),
        .DEPTH (npcusum_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_flags, f_idx, f_mag}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign {b_flags, b_idx, b_mag} = q_out;

    npcusum_back #(
        .MAX_GROUP   (MAX_GROUP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_mag           (b_mag),
        .q_idx           (b_idx),
        .q_flags         (b_flags),
        .m_ready         (m_axis_tready),
        .m_valid         (m_axis_tvalid),
        .out_stat        (o_stat),
        .out_upper       (o_upper),
        .out_lower       (o_lower),
        .out_upper_alarm (o_ua),
        .out_lower_alarm (o_la),
        .out_run_ended   (o_end),
        .out_run_length  (o_len)
    );

    assign m_axis_tdata = {{npcusum_pkg::OUT_PAD_W{1'b0}}, o_len, o_lower, o_upper, o_stat};
    assign m_axis_tuser = {o_la, o_ua};
    assign m_axis_tlast = o_end;

endmodule

// ===== dv/tb_top.sv =====
// self-checking bench for the two-sided sign / signed-rank cusum detector
// depends on npcusum_pkg and the nonparametric_cusum_detector rtl; drives samples with
// random gaps, predicts each subgroup report in-bench and compares it with m_axis words
`timescale 1ns / 1ps

module tb_top;

    localparam int  SETTLE_CYCLES = 200;
    localparam int  STALL_LIMIT   = 4000;
    localparam int  SAMPLE_TOTAL  = 1800;
    localparam int  UP_LO         = npcusum_pkg::STAT_OUT_W;
    localparam int  DN_LO         = UP_LO + npcusum_pkg::SUM_W;
    localparam int  LEN_LO        = DN_LO + npcusum_pkg::SUM_W;
    localparam longint SUM_CAP    = (64'd1 << npcusum_pkg::SUM_W) - 1;

    typedef struct {
        logic [npcusum_pkg::STAT_OUT_W-1:0] stat;
        logic [npcusum_pkg::SUM_W-1:0]      up;
        logic [npcusum_pkg::SUM_W-1:0]      dn;
        logic                               up_alarm;
        logic                               dn_alarm;
        logic                               ended;
        logic [npcusum_pkg::STEP_W-1:0]     run_len;
    } chart_report_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [15:0]                         s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [npcusum_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [npcusum_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic                                m_tlast;
    logic                                cfg_we = 1'b0;
    npcusum_pkg::cfg_reg_t               cfg_addr = npcusum_pkg::REG_CHART_MODE;
    logic [npcusum_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predicted chart state and register copies
    int                              grp[npcusum_pkg::MAX_GROUP_DEF];
    int                              fill_cnt = 0;
    longint                          up_sum = 0;
    longint                          dn_sum = 0;
    logic [npcusum_pkg::STEP_W-1:0]  run_steps = '0;
    logic                            mode_q = npcusum_pkg::CHART_MODE_RST;
    logic [npcusum_pkg::GROUP_W-1:0] size_q = npcusum_pkg::GROUP_SIZE_RST;
    logic [npcusum_pkg::REF_W-1:0]   k_q = npcusum_pkg::REF_VALUE_RST;
    logic [npcusum_pkg::LIMIT_W-1:0] h_q = npcusum_pkg::DECISION_LIMIT_RST;
    logic [npcusum_pkg::STEP_W-1:0]  lim_q = npcusum_pkg::MAX_STEPS_RST;

    logic [15:0]   samples_to_send[$];
    chart_report_t chart_reports_due[$];
    int            n_queued = 0;
    int            n_accepted = 0;
    int            n_errors = 0;
    bit            src_idle_on = 1'b1;
    bit            snk_stall_on = 1'b1;

    nonparametric_cusum_detector i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),     // sample
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),     // group_statistic, upper_sum, lower_sum, run_length
        .m_axis_tuser  (m_tuser),     // upper_alarm, lower_alarm
        .m_axis_tlast  (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic longint clip24(longint v);
        if (v < 0) return 0;
        if (v > SUM_CAP) return SUM_CAP;
        return v;
    endfunction

    task automatic flag_error(string msg);
        if (n_errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) flag_error($sformatf("%s want %0d got %0d", name, want, got));
    endtask

    // take one sample into the subgroup; at subgroup end queue the report it yields
    task automatic update_charts(logic [15:0] word);
        int            n, m;
        longint        stat, t, a, less, eq, r16;
        chart_report_t rep;
        n = int'(size_q);
        if (n == 0) n = 1;
        if (n > npcusum_pkg::MAX_GROUP_DEF) n = npcusum_pkg::MAX_GROUP_DEF;
        if (fill_cnt < npcusum_pkg::MAX_GROUP_DEF) grp[fill_cnt] = int'($signed(word));
        fill_cnt++;
        if (fill_cnt < n) return;
        m = (fill_cnt > npcusum_pkg::MAX_GROUP_DEF) ? npcusum_pkg::MAX_GROUP_DEF : fill_cnt;
        fill_cnt = 0;
        stat = 0;
        if (mode_q == npcusum_pkg::CHART_SIGN) begin
            t = 0;
            for (int i = 0; i < m; i++)
                if (grp[i] >= 0) t++;
            stat = 16 * (2 * t - m);
        end else begin
            for (int i = 0; i < m; i++) begin
                if (grp[i] == 0) continue;
                a = (grp[i] < 0) ? -longint'(grp[i]) : longint'(grp[i]);
                less = 0;
                eq = 0;
                for (int j = 0; j < m; j++) begin
                    longint b;
                    b = (grp[j] < 0) ? -longint'(grp[j]) : longint'(grp[j]);
                    if (b < a) less++;
                    else if (b == a) eq++;
                end
                // tied magnitudes share the average rank
                r16 = 16 * less + 8 * (eq + 1);
                stat += (grp[i] > 0) ? r16 : -r16;
            end
        end
        up_sum = clip24(up_sum + stat - longint'(k_q));
        dn_sum = clip24(dn_sum - stat - longint'(k_q));
        run_steps = run_steps + 1'b1;
        rep.stat     = stat[npcusum_pkg::STAT_OUT_W-1:0];
        rep.up       = up_sum[npcusum_pkg::SUM_W-1:0];
        rep.dn       = dn_sum[npcusum_pkg::SUM_W-1:0];
        rep.up_alarm = (up_sum >= longint'(h_q));
        rep.dn_alarm = (dn_sum >= longint'(h_q));
        rep.ended    = rep.up_alarm || rep.dn_alarm || (run_steps >= lim_q);
        rep.run_len  = run_steps;
        chart_reports_due = {chart_reports_due, rep};
        if (rep.ended) begin
            up_sum = 0;
            dn_sum = 0;
            run_steps = '0;
        end
    endtask

    // sample driver
    always @(posedge aclk) begin : drv
        int src_wait;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                update_charts(s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0 || samples_to_send.size() == 0) begin
                    if (src_wait > 0) src_wait--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= samples_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    src_wait = src_idle_on ? idle_len() : 0;
                end
            end
        end
    end

    // report monitor
    always @(posedge aclk) begin : mon
        int            snk_wait;
        chart_report_t rep;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (chart_reports_due.size() == 0) begin
                    flag_error($sformatf("report word with nothing pending, tdata %h", m_tdata));
                end else begin
                    rep = chart_reports_due.pop_front();
                    compare_field("group_statistic", longint'($signed(rep.stat)),
                                  longint'($signed(m_tdata[npcusum_pkg::STAT_OUT_W-1:0])));
                    compare_field("upper_sum", rep.up, m_tdata[UP_LO +: npcusum_pkg::SUM_W]);
                    compare_field("lower_sum", rep.dn, m_tdata[DN_LO +: npcusum_pkg::SUM_W]);
                    compare_field("run_length", rep.run_len,
                                  m_tdata[LEN_LO +: npcusum_pkg::STEP_W]);
                    compare_field("upper_alarm", rep.up_alarm, m_tuser[0]);
                    compare_field("lower_alarm", rep.dn_alarm, m_tuser[1]);
                    compare_field("run_ended", rep.ended, m_tlast);
                end
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (snk_stall_on && $urandom_range(0, 3) == 0) snk_wait = idle_len();
            end
        end
    end

    // watchdog on cycles without any word or register write
    always @(posedge aclk) begin : wdog
        int quiet;
        if (!aresetn) begin
            quiet = 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_sample(int v);
        samples_to_send = {samples_to_send, v[15:0]};
        n_queued++;
    endtask

    // everything sent has been taken in and reported, then let the back end settle
    task automatic wait_idle();
        while (n_accepted != n_queued || chart_reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(npcusum_pkg::cfg_reg_t r,
                             logic [npcusum_pkg::CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        case (r)
            npcusum_pkg::REG_CHART_MODE:     mode_q = v[0];
            npcusum_pkg::REG_GROUP_SIZE:     size_q = v[npcusum_pkg::GROUP_W-1:0];
            npcusum_pkg::REG_REF_VALUE:      k_q = v[npcusum_pkg::REF_W-1:0];
            npcusum_pkg::REG_DECISION_LIMIT: h_q = v[npcusum_pkg::LIMIT_W-1:0];
            npcusum_pkg::REG_MAX_STEPS:      lim_q = v[npcusum_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    // which: one bit per register index
    task automatic apply_settings(logic [4:0] which, logic mode,
                                  logic [npcusum_pkg::GROUP_W-1:0] size,
                                  logic [npcusum_pkg::REF_W-1:0] k,
                                  logic [npcusum_pkg::LIMIT_W-1:0] h,
                                  logic [npcusum_pkg::STEP_W-1:0] lim);
        wait_idle();
        if (which[npcusum_pkg::REG_CHART_MODE])
            write_reg(npcusum_pkg::REG_CHART_MODE, npcusum_pkg::CFG_DATA_W'(mode));
        if (which[npcusum_pkg::REG_GROUP_SIZE])
            write_reg(npcusum_pkg::REG_GROUP_SIZE, npcusum_pkg::CFG_DATA_W'(size));
        if (which[npcusum_pkg::REG_REF_VALUE])
            write_reg(npcusum_pkg::REG_REF_VALUE, npcusum_pkg::CFG_DATA_W'(k));
        if (which[npcusum_pkg::REG_DECISION_LIMIT])
            write_reg(npcusum_pkg::REG_DECISION_LIMIT, h);
        if (which[npcusum_pkg::REG_MAX_STEPS])
            write_reg(npcusum_pkg::REG_MAX_STEPS, lim);
        if (which != 0) begin
            @(posedge aclk);
            cfg_we <= 1'b0;
        end
    endtask

    function automatic int draw_sample(int drift);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return int'($signed(16'($urandom())));
        if (r < 40) begin
            case ($urandom_range(0, 4))
                0: return 32767;
                1: return -32768;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        // small magnitudes give plenty of ties and zeros
        if (r < 70) return int'($urandom_range(0, 8)) - 4 + drift;
        return int'($urandom_range(0, 400)) - 200 + drift;
    endfunction

    initial begin : stim
        int                              dir_a[5];
        int                              dir_b[5];
        int                              r, drift, cnt;
        bit                              first;
        logic [4:0]                      which;
        logic                            mode;
        logic [npcusum_pkg::GROUP_W-1:0] size;
        logic [npcusum_pkg::REF_W-1:0]   k;
        logic [npcusum_pkg::LIMIT_W-1:0] h;
        logic [npcusum_pkg::STEP_W-1:0]  lim;

        dir_a = '{32767, -32768, 0, -1, 1};
        dir_b = '{-32768, 32767, 0, 5, -5};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sign chart at reset settings, field extremes
        foreach (dir_a[i]) queue_sample(dir_a[i]);
        // rank chart: most negative sample, zero, tied magnitudes of opposite sign
        apply_settings(5'b1 << npcusum_pkg::REG_CHART_MODE, npcusum_pkg::CHART_RANK,
                       size_q, k_q, h_q, lim_q);
        foreach (dir_b[i]) queue_sample(dir_b[i]);
        // size lowered mid-group: next sample closes a group of four
        queue_sample(3);
        queue_sample(-3);
        queue_sample(3);
        apply_settings(5'b1 << npcusum_pkg::REG_GROUP_SIZE, mode_q, 5'd2, k_q, h_q, lim_q);
        queue_sample(9);
        // size zero acts as one, zero decision limit, zero step limit
        apply_settings((5'b1 << npcusum_pkg::REG_GROUP_SIZE)
                       | (5'b1 << npcusum_pkg::REG_DECISION_LIMIT)
                       | (5'b1 << npcusum_pkg::REG_MAX_STEPS), mode_q, 5'd0, k_q, '0, '0);
        queue_sample(0);
        queue_sample(-1);
        queue_sample(32767);

        first = 1'b1;
        while (n_queued < SAMPLE_TOTAL) begin
            if (first) which = 5'h1f;
            else if ($urandom_range(0, 5) == 0) which = 5'h00;   // plain pause
            else which = 5'($urandom_range(1, 31));
            first = 1'b0;
            mode = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 70) size = 5'($urandom_range(1, 6));
            else if (r < 82) size = 5'd16;
            else if (r < 88) size = 5'd0;
            else if (r < 94) size = 5'($urandom_range(17, 31));
            else size = 5'($urandom_range(7, 15));
            r = $urandom_range(0, 99);
            if (r < 30) k = '0;
            else if (r < 80) k = 16'($urandom_range(0, 48));
            else if (r < 90) k = '1;
            else k = 16'($urandom());
            r = $urandom_range(0, 99);
            if (r < 10) h = '0;
            else if (r < 60) h = 20'($urandom_range(0, 300));
            else if (r < 80) h = 20'($urandom_range(300, 4000));
            else if (r < 90) h = '1;
            else h = 20'($urandom());
            r = $urandom_range(0, 99);
            if (r < 10) lim = '0;
            else if (r < 20) lim = 20'd1;
            else if (r < 60) lim = 20'($urandom_range(1, 40));
            else if (r < 85) lim = 20'($urandom_range(41, 2000));
            else lim = '1;
            apply_settings(which, mode, size, k, h, lim);

            src_idle_on  = ($urandom_range(0, 3) != 0);
            snk_stall_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0, 1: drift = 0;
                2: drift = 3;
                3: drift = -3;
                4: drift = 300;
                default: drift = -300;
            endcase
            cnt = $urandom_range(30, 150);
            repeat (cnt) queue_sample(draw_sample(drift));
        end

        wait_idle();
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/npcusum_pkg.sv
hdl/npcusum_ram.sv
hdl/npcusum_queue.sv
hdl/npcusum_front.sv
hdl/npcusum_back.sv
hdl/nonparametric_cusum_detector.sv
dv/tb_top.sv
